@@ design/emss_pkg.sv @@
`timescale 1ns / 1ps

package emss_pkg;

    // Default marker length in bytes
    localparam int MARKER_LEN_DEF = 23;

    // Match counter width, fixed by the marker ROM depth
    localparam int CNT_W = 5;

    // ROM depth
    localparam int ROM_DEPTH = 32;

    // Command queue depth between front and back
    localparam int CMDQ_DEPTH = 2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Marker text, entries past the text read as zero
    localparam logic [7:0] MARKER_ROM [ROM_DEPTH] = '{
        8'h4D, 8'h65, 8'h6C, 8'h6F, 8'h64, 8'h69, 8'h6E, 8'h6B,
        8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h45, 8'h6E,
        8'h64, 8'h4F, 8'h66, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One command: replay a held prefix, then optionally one tail word
    typedef struct packed {
        logic [CNT_W-1:0] prefix_len;
        logic             tail_valid;
        kind_t            tail_kind;
        logic [7:0]       tail_byte;
    } cmd_t;

endpackage

@@ design/emss_front.sv @@
`timescale 1ns / 1ps

module emss_front #(
    parameter int MARKER_LEN = emss_pkg::MARKER_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    in_byte,
    input  logic          source_end,
    input  logic          q_full,
    output logic          cmd_push,
    output emss_pkg::cmd_t cmd
);
    import emss_pkg::*;

    logic [CNT_W-1:0] match_count_reg;
    logic [CNT_W-1:0] match_count_next;
    logic             finished_reg;
    logic             finished_next;
    logic             issue;
    logic             accept;
    logic [CNT_W:0]   count_inc;

    assign accept    = push && !q_full;
    assign count_inc = {1'b0, match_count_reg} + {{CNT_W{1'b0}}, 1'b1};

    // Classify the incoming word against the marker
    always_comb
    begin
        match_count_next = match_count_reg;
        finished_next    = finished_reg;
        issue            = 1'b0;
        cmd.prefix_len   = '0;
        cmd.tail_valid   = 1'b1;
        cmd.tail_kind    = KIND_DATA;
        cmd.tail_byte    = 8'h00;
        if (finished_reg)
        begin
            issue         = 1'b1;
            cmd.tail_kind = KIND_END;
        end
        else if (source_end)
        begin
            issue            = 1'b1;
            match_count_next = '0;
            cmd.tail_kind    = KIND_ERROR;
        end
        else if (in_byte == MARKER_ROM[match_count_reg])
        begin
            if (count_inc >= (CNT_W+1)'(MARKER_LEN))
            begin
                issue            = 1'b1;
                finished_next    = 1'b1;
                match_count_next = '0;
                cmd.tail_kind    = KIND_END;
            end
            else
            begin
                match_count_next = count_inc[CNT_W-1:0];
            end
        end
        else
        begin
            // broken match: replay held prefix; word may restart the marker
            issue          = 1'b1;
            cmd.prefix_len = match_count_reg;
            if (match_count_reg != '0 && in_byte == MARKER_ROM[0])
            begin
                match_count_next = {{(CNT_W-1){1'b0}}, 1'b1};
                cmd.tail_valid   = 1'b0;
            end
            else
            begin
                match_count_next = '0;
                cmd.tail_byte    = in_byte;
            end
        end
    end

    assign cmd_push = accept && issue;

    // Match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= '0;
            finished_reg    <= 1'b0;
        end
        else if (accept)
        begin
            match_count_reg <= match_count_next;
            finished_reg    <= finished_next;
        end
    end

`ifndef NO_ASSERTIONS
    // once the marker is found no partial match is held
    a_finished_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> match_count_reg == '0)
        else $error("match count nonzero after marker found");
`endif

endmodule

@@ design/emss_cmdq.sv @@
`timescale 1ns / 1ps

module emss_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  emss_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output logic           head_valid,
    output emss_pkg::cmd_t head
);
    import emss_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

    cmd_t              entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full       = count_reg == CNT_QW'(CMDQ_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0
                            : wr_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1};
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0
                            : rd_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1};
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + {{(CNT_QW-1){1'b0}}, 1'b1};
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - {{(CNT_QW-1){1'b0}}, 1'b1};
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_QW'(CMDQ_DEPTH))
        else $error("command queue overfilled");
`endif

endmodule

@@ design/emss_back.sv @@
`timescale 1ns / 1ps

module emss_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  emss_pkg::cmd_t head,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic [1:0]     kind,
    output logic           last
);
    import emss_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    kind_t            kind_reg;
    logic             last_reg;
    logic             step;
    logic             in_prefix;
    logic [7:0]       res_byte;
    kind_t            res_kind;
    logic             res_last;
    logic [CNT_W-1:0] idx_inc;

    assign idx_inc   = idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
    assign in_prefix = idx_reg < head.prefix_len;
    assign step      = head_valid && (!out_valid_reg || pop);

    // Pick the next result word: prefix replay, then tail
    always_comb
    begin
        if (in_prefix)
        begin
            res_byte = MARKER_ROM[idx_reg];
            res_kind = KIND_DATA;
            res_last = (idx_inc == head.prefix_len) && !head.tail_valid;
        end
        else
        begin
            res_byte = head.tail_byte;
            res_kind = head.tail_kind;
            res_last = 1'b1;
        end
    end

    assign cmd_pop  = step && res_last;
    assign idx_next = step ? (res_last ? '0 : idx_inc) : idx_reg;

    // Sequencer index and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= res_byte;
            kind_reg     <= res_kind;
            last_reg     <= res_last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign kind     = kind_reg;
    assign last     = last_reg;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg <= head.prefix_len)
        else $error("replay index past prefix");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == '0)
        else $error("replay index not cleared between commands");

    a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !head.tail_valid |-> head.prefix_len != '0)
        else $error("command with no result words");
`endif

endmodule

@@ design/end_marker_stream_stripper_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake          | Fields
// input    | push / full        | in_byte[7:0], source_end
// result   | empty / pop        | out_byte[7:0], kind[1:0], last
//
// The front takes one input word per cycle whenever the command queue
// has room; an input that extends a partial match produces no result.
// The back emits one result word per cycle while the result side is not
// stalled; an input has as many result words as it causes: 1 normally, up to MARKER_LEN on a broken
// match that replays the held prefix from the marker ROM.
// Reset clears the match state, the command queue and the output valid flag.
// A stalled result side fills the two-entry command queue, then raises full.

module end_marker_stream_stripper_unit #(
    parameter int MARKER_LEN = emss_pkg::MARKER_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       source_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);
    import emss_pkg::*;

    logic cmd_push;
    cmd_t cmd;
    logic head_valid;
    cmd_t head;
    logic cmd_pop;

    // Classifier and match state
    emss_front #(
        .MARKER_LEN(MARKER_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_byte   (in_byte),
        .source_end(source_end),
        .q_full    (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    // Command queue
    emss_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_cmd    (cmd),
        .full      (full),
        .rd_en     (cmd_pop),
        .head_valid(head_valid),
        .head      (head)
    );

    // Result sequencer
    emss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .kind      (kind),
        .last      (last)
    );

endmodule

@@ dv/emss_stream_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the stripper, predicts the result words of every
// accepted input word and compares each popped word with the oldest prediction.
module emss_stream_checker #(
    parameter int MARKER_LEN = emss_pkg::MARKER_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_byte,
    input  logic       source_end,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic [1:0] kind,
    input  logic       last,
    output int         errors,
    output int         waiting
);

    import emss_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        kind_t      code;
        logic       last;
    } result_word_t;

    // Predicted words not yet popped, oldest first
    result_word_t stripped_words[$];

    // Predictor state
    logic [CNT_W-1:0] held_len    = '0;
    logic             marker_done = 1'b0;

    int fail_count    = 0;
    int pending_words = 0;

    assign errors  = fail_count;
    assign waiting = pending_words;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Work out the result words one input word causes, in order
    task automatic predict_stripped(input logic [7:0] b, input logic src_end);
        result_word_t batch[$];
        result_word_t w;
        if (marker_done)
        begin
            w = '{8'h00, KIND_END, 1'b0};
            batch.push_back(w);
        end
        else if (src_end)
        begin
            // held prefix is dropped
            held_len = '0;
            w = '{8'h00, KIND_ERROR, 1'b0};
            batch.push_back(w);
        end
        else if (b == MARKER_ROM[held_len])
        begin
            held_len = held_len + 1'b1;
            if (held_len >= MARKER_LEN || held_len == '0)
            begin
                marker_done = 1'b1;
                held_len    = '0;
                w = '{8'h00, KIND_END, 1'b0};
                batch.push_back(w);
            end
        end
        else
        begin
            // broken match: replay the held prefix
            for (int i = 0; i < held_len; i++)
            begin
                w = '{MARKER_ROM[i], KIND_DATA, 1'b0};
                batch.push_back(w);
            end
            // current byte may start a new match
            if (held_len != '0 && b == MARKER_ROM[0])
                held_len = CNT_W'(1);
            else
            begin
                held_len = '0;
                w = '{b, KIND_DATA, 1'b0};
                batch.push_back(w);
            end
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            stripped_words.push_back(batch[i]);
    endtask

    // Compare one popped word with the oldest prediction
    task automatic compare_word();
        result_word_t exp_w;
        if (stripped_words.size() == 0)
            flag_mismatch($sformatf("unexpected word: byte %02h kind %0d last %0b",
                                    out_byte, kind, last));
        else
        begin
            exp_w = stripped_words.pop_front();
            if (out_byte !== exp_w.data)
                flag_mismatch($sformatf("out_byte got %02h exp %02h", out_byte, exp_w.data));
            if (kind !== exp_w.code)
                flag_mismatch($sformatf("kind got %0d exp %0d", kind, exp_w.code));
            if (last !== exp_w.last)
                flag_mismatch($sformatf("last got %0b exp %0b", last, exp_w.last));
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_stripped(in_byte, source_end);
            if (pop && !empty)
                compare_word();
            pending_words <= stripped_words.size();
        end
    end

endmodule

@@ dv/end_marker_stream_stripper_unit_test.sv @@
`timescale 1ns / 1ps

module end_marker_stream_stripper_unit_test;

    import emss_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int MARKER_LEN   = MARKER_LEN_DEF;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       push       = 1'b0;
    logic       full;
    logic [7:0] in_byte    = 8'h00;
    logic       source_end = 1'b0;
    logic       empty;
    logic       pop        = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    int errors;
    int waiting;

    // Idle and stall odds in percent, long hold requests
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    always #HALF_PERIOD clk = ~clk;

    end_marker_stream_stripper_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .source_end (source_end),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last)
    );

    emss_stream_checker #(
        .MARKER_LEN (MARKER_LEN)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .source_end (source_end),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last),
        .errors     (errors),
        .waiting    (waiting)
    );

    // Result side: random stalls, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_asked != hold_seen)
        begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one input word, with random gaps, until it is taken
    task automatic drive_word(input logic [7:0] b, input logic src_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        in_byte    <= b;
        source_end <= src_end;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Marker prefix of len bytes followed by a word that breaks it
    task automatic send_broken_prefix(input int len, input logic [7:0] brk,
                                      input logic brk_end);
        for (int i = 0; i < len; i++)
            drive_word(MARKER_ROM[i], 1'b0);
        drive_word(brk, brk_end);
    endtask

    // One random chunk: mostly partial markers, some noise and source ends
    task automatic send_sequence();
        int         pick;
        int         len;
        logic [7:0] brk;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            len  = $urandom_range(MARKER_LEN - 1, 1);
            pick = $urandom_range(99);
            if (pick < 30)
                send_broken_prefix(len, MARKER_ROM[0], 1'b0);
            else if (pick < 45)
                send_broken_prefix(len, 8'($urandom_range(255)), 1'b1);
            else
            begin
                // never let the break byte extend the match
                do
                    brk = 8'($urandom_range(255));
                while (brk == MARKER_ROM[len]);
                send_broken_prefix(len, brk, 1'b0);
            end
        end
        else if (pick < 80)
            repeat ($urandom_range(4, 1))
                drive_word(8'($urandom_range(255)), 1'b0);
        else if (pick < 90)
            repeat ($urandom_range(3, 1))
                drive_word(MARKER_ROM[$urandom_range(MARKER_LEN - 1)], 1'b0);
        else
            drive_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int start;
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = items_sent;
        while (items_sent - start < count)
            send_sequence();
    endtask

    // Sender pauses until every predicted word has been popped
    task automatic drain_pause();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, source end with and without held bytes,
        // broken matches that restart on the first marker byte or not
        drive_word(8'h00, 1'b0);
        drive_word(8'hFF, 1'b0);
        drive_word(8'hA5, 1'b1);
        send_broken_prefix(3, 8'h5A, 1'b1);
        send_broken_prefix(2, MARKER_ROM[0], 1'b0);
        drive_word(8'h80, 1'b0);
        send_broken_prefix(4, 8'h01, 1'b0);
        send_broken_prefix(1, MARKER_ROM[0], 1'b0);
        drive_word(8'h7F, 1'b0);
        drive_word(8'hAA, 1'b0);
        drain_pause();

        // Longest replay: all but the last marker byte, then a mismatch
        send_broken_prefix(MARKER_LEN - 1, 8'h00, 1'b0);
        run_phase(0, 0, 70);
        drain_pause();
        run_phase(86, 0, 60);
        drain_pause();
        run_phase(0, 86, 60);
        drain_pause();
        run_phase(32, 32, 60);
        drain_pause();

        // Result side holds off while the sender keeps pushing
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asked++;
        repeat (40)
            drive_word(8'($urandom_range(255)), 1'b0);
        drain_pause();

        // Full marker, then words after the end
        send_idle_pct = 32;
        stall_pct     = 32;
        for (int i = 0; i < MARKER_LEN; i++)
            drive_word(MARKER_ROM[i], 1'b0);
        drive_word(MARKER_ROM[0], 1'b0);
        drive_word(8'hC3, 1'b1);
        repeat (4)
            drive_word(8'($urandom_range(255)), 1'($urandom_range(1)));

        push      <= 1'b0;
        stall_pct  = 0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/emss_pkg.sv
design/emss_front.sv
design/emss_cmdq.sv
design/emss_back.sv
design/end_marker_stream_stripper_unit.sv
dv/emss_stream_checker.sv
dv/end_marker_stream_stripper_unit_test.sv
